// ----- rtl/crv_pkg.sv -----
// ----------------------------------------------------------------------------
// crv_pkg
// Shared widths, arctangent table and saturation helpers for the CORDIC unit.
// ----------------------------------------------------------------------------
package crv_pkg;

    localparam int XY_W       = 28;           // internal x/y, covers vectoring growth
    localparam int ANG_W      = 32;           // angle accumulator
    localparam int TGT_W      = 25;
    localparam int IN_W       = 24;
    localparam int OUT_XY_W   = 26;
    localparam int OUT_ANG_W  = 24;
    localparam int GAIN_W     = 25;
    localparam int PROD_W     = XY_W + GAIN_W;
    localparam int TABLE_LEN  = 15;
    localparam int TABLE_FRAC = 24;

    localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;

    // atan(2^-i) in degrees, scaled by 2^24
    localparam logic signed [ANG_W-1:0] ATAN_Q24 [0:TABLE_LEN-1] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671
    };

    // table entry brought to frac fraction bits, rounded half up
    function automatic logic signed [ANG_W-1:0] atan_at(input int idx, input int frac);
        int                       s;
        logic signed [ANG_W:0]    t;
        begin
            s = TABLE_FRAC - frac;
            t = {ATAN_Q24[idx][ANG_W-1], ATAN_Q24[idx]};
            if (s > 0) begin
                t = (t + ((ANG_W+1)'(1) <<< (s - 1))) >>> s;
            end
            return t[ANG_W-1:0];
        end
    endfunction

    function automatic logic signed [OUT_XY_W-1:0] sat_xy(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        begin
            hi = (PROD_W'(1) <<< (OUT_XY_W - 1)) - PROD_W'(1);
            lo = -hi - PROD_W'(1);
            if (v > hi) begin
                return hi[OUT_XY_W-1:0];
            end else if (v < lo) begin
                return lo[OUT_XY_W-1:0];
            end
            return v[OUT_XY_W-1:0];
        end
    endfunction

    function automatic logic signed [OUT_ANG_W-1:0] sat_ang(input logic signed [ANG_W:0] v);
        logic signed [ANG_W:0] hi;
        logic signed [ANG_W:0] lo;
        begin
            hi = ((ANG_W+1)'(1) <<< (OUT_ANG_W - 1)) - (ANG_W+1)'(1);
            lo = -hi - (ANG_W+1)'(1);
            if (v > hi) begin
                return hi[OUT_ANG_W-1:0];
            end else if (v < lo) begin
                return lo[OUT_ANG_W-1:0];
            end
            return v[OUT_ANG_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/cordic_rotate_vector_degrees.sv -----
// ----------------------------------------------------------------------------
// cordic_rotate_vector_degrees
// Pipelined CORDIC in degrees: sine/cosine by rotation, angle by vectoring.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | word
//  input    | in        | i_valid / o_stall     | op, target_angle, vec_x, vec_y
//  result   | out       | o_valid / i_stall     | out_x, out_y, out_angle
//
//  the pipeline is one load stage, one stage per shift-add iteration, a gain
//  multiply stage and an output stage. a new word can enter every cycle while
//  o_stall is low; each stage holds its word while the next one is full and
//  stalled, and empty stages fill up under a stall.
//  synchronous active-low reset clears the valid bits only.
module cordic_rotate_vector_degrees #(
    parameter int ITERATIONS = 15,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_op,
    input  logic signed [crv_pkg::TGT_W-1:0]      i_target_angle,
    input  logic signed [crv_pkg::IN_W-1:0]       i_vec_x,
    input  logic signed [crv_pkg::IN_W-1:0]       i_vec_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [crv_pkg::OUT_XY_W-1:0]   o_out_x,
    output logic signed [crv_pkg::OUT_XY_W-1:0]   o_out_y,
    output logic signed [crv_pkg::OUT_ANG_W-1:0]  o_out_angle
);
    import crv_pkg::*;

    localparam logic signed [XY_W-1:0] X_ONE = XY_W'(1) <<< FRAC_BITS;

    // iteration pipeline, stage 0 is the load stage
    logic                    r_v   [0:ITERATIONS];
    logic                    r_op  [0:ITERATIONS];
    logic signed [XY_W-1:0]  r_x   [0:ITERATIONS];
    logic signed [XY_W-1:0]  r_y   [0:ITERATIONS];
    logic signed [ANG_W-1:0] r_acc [0:ITERATIONS];
    logic signed [TGT_W-1:0] r_tgt [0:ITERATIONS];
    logic                    w_rdy [0:ITERATIONS];

    // multiply stage
    logic                     r_vm;
    logic                     r_mop;
    logic signed [XY_W-1:0]   r_mx;
    logic signed [XY_W-1:0]   r_my;
    logic signed [ANG_W-1:0]  r_macc;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic                     w_rdy_m;

    // output stage
    logic                        r_vo;
    logic signed [OUT_XY_W-1:0]  r_ox;
    logic signed [OUT_XY_W-1:0]  r_oy;
    logic signed [OUT_ANG_W-1:0] r_oang;
    logic                        w_rdy_o;

    logic signed [PROD_W-1:0] n_rx;
    logic signed [PROD_W-1:0] n_ry;

    assign w_rdy_o = !r_vo || !i_stall;
    assign w_rdy_m = !r_vm || w_rdy_o;
    assign w_rdy[ITERATIONS] = !r_v[ITERATIONS] || w_rdy_m;
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_stall = !w_rdy[0];

    // load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
        if (w_rdy[0] && i_valid) begin
            r_op[0]  <= i_op;
            r_acc[0] <= '0;
            r_tgt[0] <= i_target_angle;
            if (i_op) begin
                r_x[0] <= XY_W'(i_vec_x);
                r_y[0] <= XY_W'(i_vec_y);
            end else begin
                r_x[0] <= X_ONE;
                r_y[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k <= ITERATIONS; k++) begin : g_iter
        localparam logic signed [ANG_W-1:0] ATAN_K = atan_at(k - 1, FRAC_BITS);

        logic                    n_pos;
        logic signed [XY_W-1:0]  n_dx;
        logic signed [XY_W-1:0]  n_dy;

        if (k < ITERATIONS) begin : g_rdy
            assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end

        always_comb begin
            n_dx = r_y[k-1] >>> (k - 1);
            n_dy = r_x[k-1] >>> (k - 1);
            // vectoring chases y to zero, rotation chases the target angle
            if (r_op[k-1]) begin
                n_pos = r_y[k-1][XY_W-1];
            end else begin
                n_pos = r_acc[k-1] < ANG_W'(r_tgt[k-1]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= r_v[k-1];
            end
            if (w_rdy[k] && r_v[k-1]) begin
                r_op[k]  <= r_op[k-1];
                r_tgt[k] <= r_tgt[k-1];
                if (n_pos) begin
                    r_x[k]   <= r_x[k-1] - n_dx;
                    r_y[k]   <= r_y[k-1] + n_dy;
                    r_acc[k] <= r_acc[k-1] + ATAN_K;
                end else begin
                    r_x[k]   <= r_x[k-1] + n_dx;
                    r_y[k]   <= r_y[k-1] - n_dy;
                    r_acc[k] <= r_acc[k-1] - ATAN_K;
                end
            end
        end
    end

    // gain multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (w_rdy_m) begin
            r_vm <= r_v[ITERATIONS];
        end
        if (w_rdy_m && r_v[ITERATIONS]) begin
            r_mop  <= r_op[ITERATIONS];
            r_mx   <= r_x[ITERATIONS];
            r_my   <= r_y[ITERATIONS];
            r_macc <= r_acc[ITERATIONS];
            r_px   <= r_x[ITERATIONS] * GAIN_Q24;
            r_py   <= r_y[ITERATIONS] * GAIN_Q24;
        end
    end

    // round back from q24 gain
    always_comb begin
        n_rx = (r_px + (PROD_W'(1) <<< (TABLE_FRAC - 1))) >>> TABLE_FRAC;
        n_ry = (r_py + (PROD_W'(1) <<< (TABLE_FRAC - 1))) >>> TABLE_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_rdy_o) begin
            r_vo <= r_vm;
        end
        if (w_rdy_o && r_vm) begin
            if (r_mop) begin
                r_ox   <= sat_xy(PROD_W'(r_mx));
                r_oy   <= sat_xy(PROD_W'(r_my));
                r_oang <= sat_ang(-((ANG_W+1)'(r_macc)));
            end else begin
                r_ox   <= sat_xy(n_rx);
                r_oy   <= sat_xy(n_ry);
                r_oang <= '0;
            end
        end
    end

    assign o_valid     = r_vo;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_angle = r_oang;

endmodule
